[rtl/wstq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wstq_pkg;

    localparam int unsigned NumQueues = 8;
    localparam int unsigned MaxTasks  = 256;

    localparam logic [8:0] LINK_NIL = 9'd256;

    localparam logic [2:0] OP_ENQUEUE  = 3'd0;
    localparam logic [2:0] OP_PUSH_HEAD = 3'd1;
    localparam logic [2:0] OP_DEQUEUE  = 3'd2;
    localparam logic [2:0] OP_STEAL    = 3'd3;
    localparam logic [2:0] OP_REMOVE   = 3'd4;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_LATCH,
        UOP_LOAD_Q,
        UOP_LOAD_O,
        UOP_DECODE,
        UOP_INS_LINK,
        UOP_INS_JOIN,
        UOP_DEQ_READ,
        UOP_DEQ_WRITE,
        UOP_REM_READ,
        UOP_REM_WRITE,
        UOP_STEAL_SEIZE,
        UOP_STEAL_WALK,
        UOP_STEAL_VICTIM,
        UOP_STEAL_THIEF
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic [2:0] op;
        logic       has;
        logic       full;
        logic       q_empty;
        logic       steal_go;
        logic       keep_zero;
        logic       walk_last;
    } t_status;

endpackage

`default_nettype wire

[rtl/wstq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module wstq_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/wstq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module wstq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wstq_pkg::t_status i_status,
    output wstq_pkg::t_ctl   o_ctl,
    output logic             o_busy
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_LDQ    = 14'b00000000000010,
        S_LDO    = 14'b00000000000100,
        S_DEC    = 14'b00000000001000,
        S_INS1   = 14'b00000000010000,
        S_INS2   = 14'b00000000100000,
        S_DQ1    = 14'b00000001000000,
        S_DQ2    = 14'b00000010000000,
        S_RM1    = 14'b00000100000000,
        S_RM2    = 14'b00001000000000,
        S_SEIZE  = 14'b00010000000000,
        S_WALK   = 14'b00100000000000,
        S_VICT   = 14'b01000000000000,
        S_THIEF  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_ctl.uop    = wstq_pkg::UOP_NONE;
        o_ctl.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.uop = wstq_pkg::UOP_LATCH;
                    n_state   = S_LDQ;
                end
            end
            S_LDQ: begin
                o_ctl.uop = wstq_pkg::UOP_LOAD_Q;
                n_state   = S_LDO;
            end
            S_LDO: begin
                o_ctl.uop = wstq_pkg::UOP_LOAD_O;
                n_state   = S_DEC;
            end
            S_DEC: begin
                o_ctl.uop = wstq_pkg::UOP_DECODE;
                unique case (i_status.op)
                    wstq_pkg::OP_ENQUEUE, wstq_pkg::OP_PUSH_HEAD: begin
                        if (!i_status.has || i_status.full) begin
                            o_ctl.finish = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_INS1;
                        end
                    end
                    wstq_pkg::OP_DEQUEUE: begin
                        if (i_status.q_empty) begin
                            o_ctl.finish = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_DQ1;
                        end
                    end
                    wstq_pkg::OP_STEAL: begin
                        if (!i_status.steal_go) begin
                            o_ctl.finish = 1'b1;
                            n_state      = S_IDLE;
                        end else if (i_status.keep_zero) begin
                            n_state = S_VICT;
                        end else begin
                            n_state = S_SEIZE;
                        end
                    end
                    wstq_pkg::OP_REMOVE: begin
                        if (!i_status.has) begin
                            o_ctl.finish = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_RM1;
                        end
                    end
                    default: begin
                        o_ctl.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_INS1: begin
                o_ctl.uop = wstq_pkg::UOP_INS_LINK;
                n_state   = S_INS2;
            end
            S_INS2: begin
                o_ctl.uop    = wstq_pkg::UOP_INS_JOIN;
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_DQ1: begin
                o_ctl.uop = wstq_pkg::UOP_DEQ_READ;
                n_state   = S_DQ2;
            end
            S_DQ2: begin
                o_ctl.uop    = wstq_pkg::UOP_DEQ_WRITE;
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_RM1: begin
                o_ctl.uop = wstq_pkg::UOP_REM_READ;
                n_state   = S_RM2;
            end
            S_RM2: begin
                o_ctl.uop    = wstq_pkg::UOP_REM_WRITE;
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_SEIZE: begin
                o_ctl.uop = wstq_pkg::UOP_STEAL_SEIZE;
                n_state   = S_WALK;
            end
            S_WALK: begin
                o_ctl.uop = wstq_pkg::UOP_STEAL_WALK;
                if (i_status.walk_last) begin
                    n_state = S_VICT;
                end
            end
            S_VICT: begin
                o_ctl.uop = wstq_pkg::UOP_STEAL_VICTIM;
                n_state   = S_THIEF;
            end
            S_THIEF: begin
                o_ctl.uop    = wstq_pkg::UOP_STEAL_THIEF;
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_LDQ))
        else $error("request not taken into load");
    a_walk_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_status.walk_last) |=> (r_state == S_VICT))
        else $error("walk did not end in victim update");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> (r_state == S_IDLE))
        else $error("finish without return to idle");
`endif

endmodule

`default_nettype wire

[rtl/wstq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module wstq_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [8:0]        i_cfg_wdata,
    input  wire  [2:0]        i_operation,
    input  wire  [2:0]        i_queue_id,
    input  wire  [2:0]        i_other_queue,
    input  wire               i_has_task,
    input  wire  [7:0]        i_task_id,
    input  wire  [8:0]        i_min_length,
    input  wstq_pkg::t_ctl    i_ctl,
    output wstq_pkg::t_status o_status,
    output logic              o_done,
    output logic              o_ok,
    output logic              o_task_valid,
    output logic [7:0]        o_task_out,
    output logic [8:0]        o_moved_count
);

    logic [8:0] r_max;
    logic [7:0] r_head  [wstq_pkg::NumQueues];
    logic [7:0] r_tail  [wstq_pkg::NumQueues];
    logic [8:0] r_count [wstq_pkg::NumQueues];

    logic [2:0] r_op, r_q, r_o;
    logic       r_has;
    logic [7:0] r_t;
    logic [8:0] r_minl;
    logic [7:0] r_qh, r_qt, r_oh, r_ot;
    logic [8:0] r_qc, r_oc;
    logic [7:0] r_keep;
    logic [8:0] r_grab;
    logic [7:0] r_step, r_p, r_mp, r_mid;
    logic       r_strobe, r_ok, r_valid;
    logic [7:0] r_tout;
    logic [8:0] r_moved;

    logic [2:0] rsel;
    logic       qwe;
    logic [2:0] qwaddr;
    logic [7:0] qwhead, qwtail;
    logic [8:0] qwcount;

    logic       hl_we, tl_we;
    logic [7:0] hl_waddr, tl_waddr, hl_raddr, tl_raddr;
    logic [8:0] hl_wdata, tl_wdata, hl_rdata, tl_rdata;

    logic       at_head, walk_last;
    logic [7:0] walk_next;
    logic [8:0] qc_inc, qc_dec;
    logic [9:0] thief_sum;

    assign rsel      = (i_ctl.uop == wstq_pkg::UOP_LOAD_O) ? r_o : r_q;
    assign at_head   = (r_op == wstq_pkg::OP_PUSH_HEAD);
    assign walk_last = (r_step == (r_keep - 8'd1));
    assign walk_next = (hl_rdata != wstq_pkg::LINK_NIL) ? hl_rdata[7:0] : r_p;
    assign qc_inc    = (r_qc == wstq_pkg::LINK_NIL) ? r_qc : r_qc + 9'd1;
    assign qc_dec    = r_qc - 9'd1;
    assign thief_sum = {1'b0, r_qc} + {1'b0, r_grab};

    assign o_status.op        = r_op;
    assign o_status.has       = r_has;
    assign o_status.full      = (r_max != 9'd0) && (r_qc >= r_max);
    assign o_status.q_empty   = (r_qc == 9'd0);
    assign o_status.steal_go  = (r_q != r_o) && (r_oc != 9'd0) && (r_oc >= r_minl);
    assign o_status.keep_zero = (r_oc[8:1] == 8'd0);
    assign o_status.walk_last = walk_last;

    wstq_ram #(.WIDTH(9), .DEPTH(wstq_pkg::MaxTasks)) u_head_links (
        .i_clk   (i_clk),
        .i_we    (hl_we),
        .i_waddr (hl_waddr),
        .i_wdata (hl_wdata),
        .i_raddr (hl_raddr),
        .o_rdata (hl_rdata)
    );

    wstq_ram #(.WIDTH(9), .DEPTH(wstq_pkg::MaxTasks)) u_tail_links (
        .i_clk   (i_clk),
        .i_we    (tl_we),
        .i_waddr (tl_waddr),
        .i_wdata (tl_wdata),
        .i_raddr (tl_raddr),
        .o_rdata (tl_rdata)
    );

    always_comb begin
        hl_we    = 1'b0;
        hl_waddr = r_t;
        hl_wdata = wstq_pkg::LINK_NIL;
        hl_raddr = r_t;
        tl_we    = 1'b0;
        tl_waddr = r_t;
        tl_wdata = wstq_pkg::LINK_NIL;
        tl_raddr = r_t;
        qwe      = 1'b0;
        qwaddr   = r_q;
        qwhead   = r_qh;
        qwtail   = r_qt;
        qwcount  = r_qc;
        case (i_ctl.uop)
            wstq_pkg::UOP_INS_LINK: begin
                if (r_qc != 9'd0) begin
                    if (at_head) begin
                        hl_we    = 1'b1;
                        hl_waddr = r_qh;
                        hl_wdata = {1'b0, r_t};
                    end else begin
                        tl_we    = 1'b1;
                        tl_waddr = r_qt;
                        tl_wdata = {1'b0, r_t};
                    end
                end
            end
            wstq_pkg::UOP_INS_JOIN: begin
                qwe      = 1'b1;
                qwcount  = qc_inc;
                hl_we    = 1'b1;
                hl_wdata = (r_qc != 9'd0 && !at_head) ? {1'b0, r_qt} : wstq_pkg::LINK_NIL;
                tl_we    = 1'b1;
                tl_wdata = (r_qc != 9'd0 && at_head) ? {1'b0, r_qh} : wstq_pkg::LINK_NIL;
                if (r_qc == 9'd0) begin
                    qwhead = r_t;
                    qwtail = r_t;
                end else if (at_head) begin
                    qwhead = r_t;
                end else begin
                    qwtail = r_t;
                end
            end
            wstq_pkg::UOP_DEQ_READ: begin
                tl_raddr = r_qh;
            end
            wstq_pkg::UOP_DEQ_WRITE: begin
                qwe = 1'b1;
                if (qc_dec != 9'd0 && tl_rdata != wstq_pkg::LINK_NIL) begin
                    hl_we    = 1'b1;
                    hl_waddr = tl_rdata[7:0];
                    qwhead   = tl_rdata[7:0];
                    qwcount  = qc_dec;
                end else begin
                    qwhead  = 8'd0;
                    qwtail  = 8'd0;
                    qwcount = 9'd0;
                end
            end
            wstq_pkg::UOP_REM_WRITE: begin
                if (tl_rdata != wstq_pkg::LINK_NIL) begin
                    hl_we    = 1'b1;
                    hl_waddr = tl_rdata[7:0];
                    hl_wdata = hl_rdata;
                end
                if (hl_rdata != wstq_pkg::LINK_NIL) begin
                    tl_we    = 1'b1;
                    tl_waddr = hl_rdata[7:0];
                    tl_wdata = tl_rdata;
                end
                if (r_qc != 9'd0) begin
                    qwe     = 1'b1;
                    qwcount = qc_dec;
                    if (r_qt == r_t) begin
                        qwtail = (hl_rdata == wstq_pkg::LINK_NIL) ? 8'd0 : hl_rdata[7:0];
                    end
                    if (r_qh == r_t) begin
                        qwhead = (tl_rdata == wstq_pkg::LINK_NIL) ? 8'd0 : tl_rdata[7:0];
                    end
                end
            end
            wstq_pkg::UOP_STEAL_SEIZE: begin
                hl_raddr = r_ot;
            end
            wstq_pkg::UOP_STEAL_WALK: begin
                hl_raddr = walk_next;
            end
            wstq_pkg::UOP_STEAL_VICTIM: begin
                qwe     = 1'b1;
                qwaddr  = r_o;
                qwcount = {1'b0, r_keep};
                tl_we    = 1'b1;
                tl_waddr = r_mid;
                if (r_keep != 8'd0) begin
                    hl_we    = 1'b1;
                    hl_waddr = r_mp;
                    qwhead   = r_mp;
                    qwtail   = r_ot;
                end else begin
                    qwhead = 8'd0;
                    qwtail = 8'd0;
                end
            end
            wstq_pkg::UOP_STEAL_THIEF: begin
                qwe      = 1'b1;
                qwcount  = (thief_sum > {1'b0, wstq_pkg::LINK_NIL}) ?
                           wstq_pkg::LINK_NIL : thief_sum[8:0];
                qwtail   = r_mid;
                hl_we    = 1'b1;
                hl_waddr = r_oh;
                if (r_qc == 9'd0) begin
                    qwhead = r_oh;
                end else begin
                    hl_wdata = {1'b0, r_qt};
                    tl_we    = 1'b1;
                    tl_waddr = r_qt;
                    tl_wdata = {1'b0, r_oh};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= 9'd0;
            r_strobe <= 1'b0;
            for (int i = 0; i < wstq_pkg::NumQueues; i++) begin
                r_head[i]  <= 8'd0;
                r_tail[i]  <= 8'd0;
                r_count[i] <= 9'd0;
            end
        end else begin
            r_strobe <= i_ctl.finish;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (qwe) begin
                r_head[qwaddr]  <= qwhead;
                r_tail[qwaddr]  <= qwtail;
                r_count[qwaddr] <= qwcount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.uop)
            wstq_pkg::UOP_LATCH: begin
                r_op    <= i_operation;
                r_q     <= i_queue_id;
                r_o     <= i_other_queue;
                r_has   <= i_has_task;
                r_t     <= i_task_id;
                r_minl  <= i_min_length;
                r_ok    <= 1'b0;
                r_valid <= 1'b0;
                r_tout  <= 8'd0;
                r_moved <= 9'd0;
            end
            wstq_pkg::UOP_LOAD_Q: begin
                r_qh <= r_head[rsel];
                r_qt <= r_tail[rsel];
                r_qc <= r_count[rsel];
            end
            wstq_pkg::UOP_LOAD_O: begin
                r_oh <= r_head[rsel];
                r_ot <= r_tail[rsel];
                r_oc <= r_count[rsel];
            end
            wstq_pkg::UOP_DECODE: begin
                r_ok   <= (r_op == wstq_pkg::OP_ENQUEUE || r_op == wstq_pkg::OP_PUSH_HEAD)
                          && !r_has;
                r_keep <= r_oc[8:1];
                r_grab <= r_oc - {1'b0, r_oc[8:1]};
                r_mid  <= r_ot;
            end
            wstq_pkg::UOP_INS_JOIN: begin
                r_ok <= 1'b1;
            end
            wstq_pkg::UOP_DEQ_WRITE: begin
                r_valid <= 1'b1;
                r_tout  <= r_qh;
            end
            wstq_pkg::UOP_STEAL_SEIZE: begin
                r_p    <= r_ot;
                r_step <= 8'd0;
            end
            wstq_pkg::UOP_STEAL_WALK: begin
                if (walk_last) begin
                    r_mp  <= r_p;
                    r_mid <= walk_next;
                end else begin
                    r_p    <= walk_next;
                    r_step <= r_step + 8'd1;
                end
            end
            wstq_pkg::UOP_STEAL_THIEF: begin
                r_moved <= r_grab;
            end
            default: begin
            end
        endcase
    end

    assign o_done        = r_strobe;
    assign o_ok          = r_ok;
    assign o_task_valid  = r_valid;
    assign o_task_out    = r_tout;
    assign o_moved_count = r_moved;

`ifndef SYNTHESIS
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_task_valid && (o_ok || o_moved_count != 9'd0)))
        else $error("result mixes operation kinds");
    a_moved_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.uop == wstq_pkg::UOP_STEAL_THIEF) |-> (r_grab != 9'd0 && r_grab <= r_oc))
        else $error("steal moves an impossible number of tasks");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.uop == wstq_pkg::UOP_STEAL_WALK) |-> (r_step < r_keep))
        else $error("walk ran past its step count");
`endif

endmodule

`default_nettype wire

[rtl/work_stealing_task_queues_core.sv]
// Accepted inserts, dequeue and remove pass load, decode and their own update states; a request ends at
// decode for a refused or absent insert, empty dequeue, absent remove, no steal or a spare op.
// Steal walks the floor(n/2) tasks a victim keeps, one link read a cycle; one task skips the walk.
// One request at a time; busy is high from acceptance until the result cycle.
// Result is shown for one cycle with o_done; the receiver cannot stall.
// Synchronous active-low reset clears queue state and max_count; link store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module work_stealing_task_queues_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        i_cfg_we,
    input  wire  [8:0] i_cfg_wdata,
    input  wire  [2:0] i_operation,
    input  wire  [2:0] i_queue_id,
    input  wire  [2:0] i_other_queue,
    input  wire        i_has_task,
    input  wire  [7:0] i_task_id,
    input  wire  [8:0] i_min_length,
    output logic       o_done,
    output logic       o_ok,
    output logic       o_task_valid,
    output logic [7:0] o_task_out,
    output logic [8:0] o_moved_count
);

    wstq_pkg::t_ctl    ctl;
    wstq_pkg::t_status status;

    wstq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    wstq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_operation   (i_operation),
        .i_queue_id    (i_queue_id),
        .i_other_queue (i_other_queue),
        .i_has_task    (i_has_task),
        .i_task_id     (i_task_id),
        .i_min_length  (i_min_length),
        .i_ctl         (ctl),
        .o_status      (status),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_task_valid  (o_task_valid),
        .o_task_out    (o_task_out),
        .o_moved_count (o_moved_count)
    );

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned NIL = wstq_pkg::MaxTasks;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * wstq_pkg::MaxTasks;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] q;
        logic [2:0] other;
        logic       has;
        logic [7:0] tid;
        logic [8:0] minl;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic       tv;
        logic [7:0] tout;
        logic [8:0] moved;
    } reply_t;

    logic i_clk, i_rst_n, start, busy, i_cfg_we;
    logic [8:0] i_cfg_wdata;
    logic [2:0] i_operation, i_queue_id, i_other_queue;
    logic i_has_task;
    logic [7:0] i_task_id;
    logic [8:0] i_min_length;
    logic o_done, o_ok, o_task_valid;
    logic [7:0] o_task_out;
    logic [8:0] o_moved_count;

    work_stealing_task_queues_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_operation(i_operation), .i_queue_id(i_queue_id),
        .i_other_queue(i_other_queue), .i_has_task(i_has_task),
        .i_task_id(i_task_id), .i_min_length(i_min_length),
        .o_done(o_done), .o_ok(o_ok), .o_task_valid(o_task_valid),
        .o_task_out(o_task_out), .o_moved_count(o_moved_count)
    );

    // queue model
    int unsigned limit_cnt;
    int unsigned head_of[wstq_pkg::NumQueues], tail_of[wstq_pkg::NumQueues];
    int unsigned len_of[wstq_pkg::NumQueues];
    int unsigned link_h[wstq_pkg::MaxTasks], link_t[wstq_pkg::MaxTasks];
    bit linked[wstq_pkg::MaxTasks];

    req_t pending[$];
    reply_t awaited[$];
    req_t cur;
    bit calm, failed;
    int idle_cycles;

    function automatic int unsigned hget(int unsigned t);
        return t < NIL ? link_h[t] : NIL;
    endfunction

    function automatic int unsigned tget(int unsigned t);
        return t < NIL ? link_t[t] : NIL;
    endfunction

    task automatic hset(int unsigned t, int unsigned v);
        if (t < NIL) link_h[t] = v;
    endtask

    task automatic tset(int unsigned t, int unsigned v);
        if (t < NIL) link_t[t] = v;
    endtask

    task automatic grow(int unsigned q, int unsigned n);
        len_of[q] = (len_of[q] + n > NIL) ? NIL : len_of[q] + n;
    endtask

    task automatic link_in(int unsigned q, int unsigned t, bit at_head, output bit ok);
        ok = !(limit_cnt != 0 && len_of[q] >= limit_cnt);
        if (ok) begin
            linked[t] = 1;
            if (len_of[q] == 0) begin
                hset(t, NIL); tset(t, NIL);
                head_of[q] = t; tail_of[q] = t;
            end else if (at_head) begin
                hset(head_of[q], t); tset(t, head_of[q]); hset(t, NIL);
                head_of[q] = t;
            end else begin
                tset(tail_of[q], t); hset(t, tail_of[q]); tset(t, NIL);
                tail_of[q] = t;
            end
            grow(q, 1);
        end
    endtask

    task automatic steal_half(int unsigned q, int unsigned o, int unsigned minl,
                              output int unsigned grab);
        int unsigned n, keep, mid, last, mp, nx;
        n = len_of[o];
        grab = 0;
        if (!(q == o || n == 0 || n < minl)) begin
            keep = n / 2;
            grab = n - keep;
            last = head_of[o];
            if (keep > 0) begin
                mp = tail_of[o];
                for (int i = 0; i < keep - 1; i++) begin
                    nx = hget(mp);
                    if (nx == NIL) break;
                    mp = nx;
                end
                mid = hget(mp);
                if (mid == NIL) mid = mp;
                head_of[o] = mp;
                hset(mp, NIL);
            end else begin
                mid = tail_of[o];
                head_of[o] = 0; tail_of[o] = 0;
            end
            len_of[o] = keep;
            tset(mid, NIL);
            if (len_of[q] == 0) begin
                tail_of[q] = mid; head_of[q] = last;
                hset(last, NIL);
            end else begin
                tset(tail_of[q], last); hset(last, tail_of[q]);
                tail_of[q] = mid;
            end
            grow(q, grab);
        end
    endtask

    task automatic unlink(int unsigned q, int unsigned t);
        int unsigned th, tt;
        th = hget(t); tt = tget(t);
        if (tt != NIL) hset(tt, th);
        if (th != NIL) tset(th, tt);
        if (len_of[q] != 0) begin
            if (tail_of[q] == t) tail_of[q] = (th == NIL) ? 0 : th;
            if (head_of[q] == t) head_of[q] = (tt == NIL) ? 0 : tt;
            len_of[q] -= 1;
        end
    endtask

    task automatic predict_reply(req_t r, output reply_t y);
        int unsigned ret, nx, grab;
        bit ok;
        y = '0;
        case (r.op)
            wstq_pkg::OP_ENQUEUE, wstq_pkg::OP_PUSH_HEAD: begin
                if (r.has) begin
                    link_in(r.q, r.tid, r.op == wstq_pkg::OP_PUSH_HEAD, ok);
                    y.ok = ok;
                end else begin
                    y.ok = 1;
                end
            end
            wstq_pkg::OP_DEQUEUE: begin
                if (len_of[r.q] != 0) begin
                    ret = head_of[r.q];
                    nx = tget(ret);
                    y.tv = 1;
                    y.tout = ret[7:0];
                    len_of[r.q] -= 1;
                    if (len_of[r.q] != 0 && nx != NIL) begin
                        head_of[r.q] = nx;
                        hset(nx, NIL);
                    end else begin
                        len_of[r.q] = 0; head_of[r.q] = 0; tail_of[r.q] = 0;
                    end
                end
            end
            wstq_pkg::OP_STEAL: begin
                steal_half(r.q, r.other, r.minl, grab);
                y.moved = grab[8:0];
            end
            wstq_pkg::OP_REMOVE: if (r.has) unlink(r.q, r.tid);
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        reply_t y;
        if (!i_rst_n) begin
            start <= 0;
        end else begin
            if (start && !busy) begin
                predict_reply(cur, y);
                awaited.push_back(y);
            end
            if (!start || !busy) begin
                if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
                    cur = pending.pop_front();
                    i_operation <= cur.op;
                    i_queue_id <= cur.q;
                    i_other_queue <= cur.other;
                    i_has_task <= cur.has;
                    i_task_id <= cur.tid;
                    i_min_length <= cur.minl;
                    start <= 1;
                end else begin
                    start <= 0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        reply_t e;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited.size() == 0) begin
                    $error("result with nothing awaited");
                    failed = 1;
                end else begin
                    e = awaited.pop_front();
                    if (o_ok !== e.ok) begin
                        $error("ok: expected %0d actual %0d", e.ok, o_ok); failed = 1;
                    end
                    if (o_task_valid !== e.tv) begin
                        $error("task_valid: expected %0d actual %0d", e.tv, o_task_valid);
                        failed = 1;
                    end
                    if (o_task_out !== e.tout) begin
                        $error("task_out: expected %0d actual %0d", e.tout, o_task_out);
                        failed = 1;
                    end
                    if (o_moved_count !== e.moved) begin
                        $error("moved_count: expected %0d actual %0d", e.moved, o_moved_count);
                        failed = 1;
                    end
                end
            end
            idle_cycles = (o_done || (start && !busy)) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add(logic [2:0] op, int q, int o, bit has, int t, int m);
        req_t r;
        r.op = op; r.q = 3'(q); r.other = 3'(o); r.has = has; r.tid = 8'(t);
        r.minl = 9'(m);
        pending.push_back(r);
    endtask

    task automatic drain();
        wait (pending.size() == 0 && !start && awaited.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic set_limit(int unsigned v);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= 9'(v);
        limit_cnt = v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // build a batch of mostly well-formed requests from the current model state
    task automatic make_batch(int n);
        int unsigned owner[wstq_pkg::MaxTasks];
        bit taken[wstq_pkg::MaxTasks];
        int unsigned t, q, o, pick, roll;
        int guard;
        for (int i = 0; i < wstq_pkg::MaxTasks; i++) begin
            owner[i] = wstq_pkg::NumQueues; taken[i] = 0;
        end
        for (int k = 0; k < wstq_pkg::NumQueues; k++) begin
            t = head_of[k];
            for (int s = 0; s < len_of[k] && t < NIL; s++) begin
                owner[t] = k;
                t = link_t[t];
            end
        end
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            q = $urandom_range(0, wstq_pkg::NumQueues - 1);
            o = $urandom_range(0, wstq_pkg::NumQueues - 1);
            if (roll < 40) begin
                pick = $urandom_range(0, wstq_pkg::MaxTasks - 1);
                guard = 0;
                while ((owner[pick] != wstq_pkg::NumQueues || taken[pick]) && guard < 64) begin
                    pick = $urandom_range(0, wstq_pkg::MaxTasks - 1); guard++;
                end
                if (guard < 64 || $urandom_range(0, 9) == 0) begin
                    taken[pick] = 1;
                    add(roll < 28 ? wstq_pkg::OP_ENQUEUE : wstq_pkg::OP_PUSH_HEAD, q, o,
                        $urandom_range(0, 19) != 0, pick, $urandom_range(0, 256));
                end else begin
                    add(wstq_pkg::OP_DEQUEUE, q, o, $urandom_range(0, 1), pick,
                        $urandom_range(0, 256));
                end
            end else if (roll < 62) begin
                add(wstq_pkg::OP_DEQUEUE, q, o, $urandom_range(0, 1), $urandom_range(0, 255),
                    $urandom_range(0, 256));
            end else if (roll < 80) begin
                add(wstq_pkg::OP_STEAL, q, o, $urandom_range(0, 1), $urandom_range(0, 255),
                    $urandom_range(0, 2) == 0 ? $urandom_range(0, 256)
                                              : $urandom_range(0, len_of[o] + 1));
            end else if (roll < 95) begin
                pick = $urandom_range(0, wstq_pkg::MaxTasks - 1);
                guard = 0;
                while (!(owner[pick] == q && !taken[pick]) && guard < 300) begin
                    pick = $urandom_range(0, wstq_pkg::MaxTasks - 1); guard++;
                end
                if (guard < 300) begin
                    taken[pick] = 1;
                    add(wstq_pkg::OP_REMOVE, q, o, 1, pick, $urandom_range(0, 256));
                end else if (linked[pick] && !taken[pick] && $urandom_range(0, 3) == 0) begin
                    add(wstq_pkg::OP_REMOVE, q, o, 1, pick, $urandom_range(0, 256));
                end else begin
                    add(wstq_pkg::OP_REMOVE, q, o, 0, $urandom_range(0, 255),
                        $urandom_range(0, 256));
                end
            end else begin
                add(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), q, o,
                    $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 256));
            end
        end
    endtask

    initial begin
        int unsigned limits[8] = '{256, 0, 2, 5, 1, 0, 3, 0};
        failed = 0; calm = 0; idle_cycles = 0; limit_cnt = 0;
        for (int i = 0; i < wstq_pkg::NumQueues; i++) begin
            head_of[i] = 0; tail_of[i] = 0; len_of[i] = 0;
        end
        for (int i = 0; i < wstq_pkg::MaxTasks; i++) begin
            link_h[i] = 0; link_t[i] = 0; linked[i] = 0;
        end
        i_rst_n = 0; start = 0; i_cfg_we = 0; i_cfg_wdata = 0;
        i_operation = 0; i_queue_id = 0; i_other_queue = 0;
        i_has_task = 0; i_task_id = 0; i_min_length = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        add(wstq_pkg::OP_ENQUEUE, 0, 0, 1, 0, 0);
        add(wstq_pkg::OP_ENQUEUE, 0, 0, 1, 255, 0);
        add(wstq_pkg::OP_PUSH_HEAD, 0, 0, 1, 10, 0);
        add(wstq_pkg::OP_ENQUEUE, 7, 0, 1, 20, 0);
        add(wstq_pkg::OP_ENQUEUE, 3, 0, 0, 5, 0);
        add(wstq_pkg::OP_REMOVE, 3, 0, 0, 5, 0);
        add(wstq_pkg::OP_DEQUEUE, 5, 0, 0, 0, 0);
        add(wstq_pkg::OP_STEAL, 1, 0, 0, 0, 0);
        add(wstq_pkg::OP_STEAL, 1, 1, 0, 0, 0);
        add(wstq_pkg::OP_STEAL, 2, 0, 0, 0, 256);
        add(wstq_pkg::OP_STEAL, 2, 7, 0, 0, 1);
        add(wstq_pkg::OP_DEQUEUE, 1, 0, 0, 0, 0);
        add(wstq_pkg::OP_REMOVE, 1, 0, 1, 0, 0);
        add(OP_SPARE_FIRST, 0, 0, 1, 255, 256);
        add(OP_SPARE_LAST, 7, 7, 1, 255, 256);
        add(wstq_pkg::OP_ENQUEUE, 4, 0, 1, 1, 0);
        add(wstq_pkg::OP_ENQUEUE, 4, 0, 1, 2, 0);
        add(wstq_pkg::OP_ENQUEUE, 4, 0, 1, 3, 0);
        add(wstq_pkg::OP_REMOVE, 4, 0, 1, 2, 0);
        add(wstq_pkg::OP_REMOVE, 4, 0, 1, 1, 0);
        add(wstq_pkg::OP_REMOVE, 4, 0, 1, 3, 0);
        add(wstq_pkg::OP_DEQUEUE, 2, 0, 0, 0, 0);
        set_limit(1);
        add(wstq_pkg::OP_ENQUEUE, 6, 0, 1, 30, 0);
        add(wstq_pkg::OP_ENQUEUE, 6, 0, 1, 31, 0);
        add(wstq_pkg::OP_PUSH_HEAD, 6, 0, 1, 31, 0);
        add(wstq_pkg::OP_DEQUEUE, 6, 0, 0, 0, 0);

        for (int b = 0; b < 52; b++) begin
            if (b % 7 == 0) set_limit(limits[(b / 7) % 8]);
            else drain();
            calm = (b >= 20 && b < 30);
            make_batch(25);
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && awaited.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/wstq_pkg.sv
rtl/wstq_ram.sv
rtl/wstq_ctrl.sv
rtl/wstq_dp.sv
rtl/work_stealing_task_queues_core.sv
dv/testbench.sv
